/* design/hcm_pkg.sv */
package hcm_pkg;

   localparam int PATTERN_W  = 8;
   localparam int NEURON_W   = 6;
   localparam int ELEM_W     = 8;
   localparam int PROD_W     = 16;
   localparam int COUPLING_W = 24;
   localparam int FIRST_W    = 8;
   localparam int COUNT_W    = 9;
   localparam int NCOUNT_W   = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_PATTERN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEURON_COUNT  = 2'd2;

   localparam logic [FIRST_W-1:0]  FIRST_RESET  = 8'd0;
   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 9'd256;
   localparam logic [NCOUNT_W-1:0] NCOUNT_RESET = 7'd64;

   typedef logic signed [ELEM_W-1:0]     elem_type;
   typedef logic signed [COUPLING_W-1:0] coupling_type;

   typedef struct packed {
      logic accept;
      logic load;
      logic issue;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic query_hit;
      logic window_end;
      logic pipe_busy;
   } status_type;

endpackage

/* design/hcm_ifs.sv */
interface hcm_req_if;
   logic                                valid;
   logic                                ready;
   logic                                mode;
   logic [hcm_pkg::PATTERN_W-1:0]       pattern_index;
   logic [hcm_pkg::NEURON_W-1:0]        row_neuron;
   logic [hcm_pkg::NEURON_W-1:0]        col_neuron;
   hcm_pkg::elem_type                   element_value;

   modport source (output valid, mode, pattern_index, row_neuron, col_neuron,
                   element_value, input ready);
   modport sink (input valid, mode, pattern_index, row_neuron, col_neuron,
                 element_value, output ready);
endinterface

interface hcm_rsp_if;
   logic                   valid;
   logic                   ready;
   hcm_pkg::coupling_type  coupling;

   modport source (output valid, coupling, input ready);
   modport sink (input valid, coupling, output ready);
endinterface

interface hcm_csr_if;
   logic                            valid;
   logic                            ready;
   logic [hcm_pkg::CSR_IDX_W-1:0]   index;
   logic [hcm_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* design/hcm_ram.sv */
module hcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/hcm_ctrl.sv */
module hcm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  hcm_pkg::status_type status,
   output hcm_pkg::cmd_type    cmd
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.query_hit) begin
                  cmd.load = 1'b1;
                  state_in = S_RUN;
               end
            end
         end
         S_RUN: begin
            if (status.window_end) begin
               state_in = S_DRAIN;
            end else begin
               cmd.issue = 1'b1;
            end
         end
         S_DRAIN: begin
            if (!status.pipe_busy && (!rsp_valid_ff || rsp_ready)) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* design/hcm_datapath.sv */
module hcm_datapath #(
   parameter int MAX_NEURONS  = 64,
   parameter int MAX_PATTERNS = 256
) (
   input  logic                             clock,
   input  logic                             reset,
   input  hcm_pkg::cmd_type                 cmd,
   output hcm_pkg::status_type              status,
   input  logic                             req_mode,
   input  logic [hcm_pkg::PATTERN_W-1:0]    req_pattern_index,
   input  logic [hcm_pkg::NEURON_W-1:0]     req_row_neuron,
   input  logic [hcm_pkg::NEURON_W-1:0]     req_col_neuron,
   input  hcm_pkg::elem_type                req_element_value,
   input  logic                             csr_valid,
   input  logic [hcm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hcm_pkg::CSR_DATA_W-1:0]   csr_data,
   output hcm_pkg::coupling_type            rsp_coupling
);

   localparam int PW    = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1;
   localparam int NW    = $clog2(MAX_NEURONS);
   localparam int AW    = PW + NW;
   localparam int DEPTH = 2 ** AW;

   logic [hcm_pkg::FIRST_W-1:0]  first_ff;
   logic [hcm_pkg::COUNT_W-1:0]  count_ff;
   logic [hcm_pkg::NCOUNT_W-1:0] ncount_ff;
   logic [hcm_pkg::NCOUNT_W-1:0] used;

   logic [hcm_pkg::COUNT_W-1:0]  p_ff, remaining_ff;
   logic [NW-1:0]                row_ff, col_ff;
   logic                         rd_vld_ff, prod_vld_ff;
   logic signed [hcm_pkg::PROD_W-1:0] prod_ff;
   hcm_pkg::coupling_type        acc_ff, coupling_ff;

   logic                         row_ok, pat_ok, wr_en;
   logic [AW-1:0]                wr_addr, rd_addr_row, rd_addr_col;
   logic [hcm_pkg::ELEM_W-1:0]   rd_row_data, rd_col_data;

   always_comb begin
      if (int'(ncount_ff) > MAX_NEURONS) begin
         used = hcm_pkg::NCOUNT_W'(MAX_NEURONS);
      end else begin
         used = ncount_ff;
      end
   end

   assign row_ok = ({1'b0, req_row_neuron} < used);
   assign pat_ok = (int'(req_pattern_index) < MAX_PATTERNS);
   assign wr_en  = cmd.accept && (req_mode == hcm_pkg::MODE_WRITE) && pat_ok && row_ok;

   assign wr_addr     = {PW'(req_pattern_index), NW'(req_row_neuron)};
   assign rd_addr_row = {PW'(p_ff), row_ff};
   assign rd_addr_col = {PW'(p_ff), col_ff};

   assign status.query_hit  = (req_mode == hcm_pkg::MODE_QUERY) && row_ok
                              && (req_col_neuron < req_row_neuron);
   assign status.window_end = (remaining_ff == '0) || (int'(p_ff) >= MAX_PATTERNS);
   assign status.pipe_busy  = rd_vld_ff || prod_vld_ff;

   // Two copies of the store give one row and one column element per cycle.
   hcm_ram #(.WIDTH(hcm_pkg::ELEM_W), .DEPTH(DEPTH)) u_store_row (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_element_value),
      .rd_addr (rd_addr_row),
      .rd_data (rd_row_data)
   );

   hcm_ram #(.WIDTH(hcm_pkg::ELEM_W), .DEPTH(DEPTH)) u_store_col (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_element_value),
      .rd_addr (rd_addr_col),
      .rd_data (rd_col_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff    <= hcm_pkg::FIRST_RESET;
         count_ff    <= hcm_pkg::COUNT_RESET;
         ncount_ff   <= hcm_pkg::NCOUNT_RESET;
         rd_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               hcm_pkg::CSR_FIRST_PATTERN: first_ff  <= csr_data[hcm_pkg::FIRST_W-1:0];
               hcm_pkg::CSR_PATTERN_COUNT: count_ff  <= csr_data;
               hcm_pkg::CSR_NEURON_COUNT:  ncount_ff <= csr_data[hcm_pkg::NCOUNT_W-1:0];
               default: begin
               end
            endcase
         end
         rd_vld_ff   <= cmd.issue;
         prod_vld_ff <= rd_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         p_ff         <= {1'b0, first_ff};
         remaining_ff <= count_ff;
         row_ff       <= NW'(req_row_neuron);
         col_ff       <= NW'(req_col_neuron);
      end else if (cmd.issue) begin
         p_ff         <= p_ff + 1'b1;
         remaining_ff <= remaining_ff - 1'b1;
      end
      prod_ff <= $signed(rd_row_data) * $signed(rd_col_data);
      if (cmd.load) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + hcm_pkg::COUPLING_W'(prod_ff);
      end
      if (cmd.publish) begin
         coupling_ff <= acc_ff;
      end
   end

   assign rsp_coupling = coupling_ff;

endmodule

/* design/hebbian_coupling_matrix_top.sv */
// Hebbian coupling engine. Words on req_if either store one signed pattern
// element (mode 0) at pattern_index and row_neuron, or query the coupling of
// neurons row_neuron and col_neuron (mode 1) over the pattern window set by
// the csr_if registers first_pattern, pattern_count and neuron_count.
// A query with col_neuron below row_neuron and row_neuron in use walks W
// patterns, W being pattern_count clipped at the end of the store, with one
// multiply-accumulate per cycle fed by two copies of the pattern memory; its
// word appears on rsp_if once the walk is done and the pipeline has drained,
// and the next word can be taken in the cycle that it appears. Any other
// query is consumed and returns nothing. A finished coupling waits in an
// output register; a following store word or query is taken meanwhile, and
// a query stalls at its end only while that register is still full.
// Reset restores first_pattern 0, pattern_count 256 and neuron_count 64 and
// empties the pipeline; the pattern memory holds nothing defined until written.
// Registers are to be written only while the engine is idle; the engine does
// not enforce this itself. csr_if is always ready.
module hebbian_coupling_matrix_top #(
   parameter int MAX_NEURONS  = 64,
   parameter int MAX_PATTERNS = 256
) (
   input  logic       clock,
   input  logic       reset,
   hcm_req_if.sink    req_if,
   hcm_rsp_if.source  rsp_if,
   hcm_csr_if.sink    csr_if
);

   hcm_pkg::cmd_type    cmd;
   hcm_pkg::status_type status;

   assign csr_if.ready = 1'b1;

   hcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hcm_datapath #(
      .MAX_NEURONS  (MAX_NEURONS),
      .MAX_PATTERNS (MAX_PATTERNS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_mode          (req_if.mode),
      .req_pattern_index (req_if.pattern_index),
      .req_row_neuron    (req_if.row_neuron),
      .req_col_neuron    (req_if.col_neuron),
      .req_element_value (req_if.element_value),
      .csr_valid         (csr_if.valid),
      .csr_index         (csr_if.index),
      .csr_data          (csr_if.data),
      .rsp_coupling      (rsp_if.coupling)
   );

endmodule
